// File: sv/tsts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time signal target scheduler: shared package
// Tick constants, constant divisors, pipeline beat types and register codes.
// ----------------------------------------------------------------------------
package tsts_pkg;

    // time base, 100 ns ticks
    localparam logic [63:0] TICKS_PER_MS   = 64'd10000;
    localparam logic [63:0] TICKS_PER_SEC  = 64'd10000000;
    localparam logic [63:0] TICKS_PER_MIN  = 64'd60 * TICKS_PER_SEC;
    localparam logic [63:0] TICKS_PER_DAY  = 64'd1440 * TICKS_PER_MIN;
    localparam logic [63:0] LEAD_MIN       = 64'd4500 * TICKS_PER_MS;
    localparam logic [63:0] LEAD_MAX       = 64'd5500 * TICKS_PER_MS;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int MINUTES_PER_DAY  = 1440;
    localparam int HOURS_PER_DAY    = 24;

    // day = 2^14 * DAY_UNIT, minute = 2^9 * MIN_UNIT
    localparam int DAY_SHIFT = 14;
    localparam int MIN_SHIFT = 9;
    localparam logic [63:0] DAY_UNIT = TICKS_PER_DAY >> DAY_SHIFT;
    localparam logic [63:0] MIN_UNIT = TICKS_PER_MIN >> MIN_SHIFT;

    // long division of displayed_time >> 14 by DAY_UNIT, one digit per stage
    localparam int DIGIT_W    = 4;
    localparam int DIV_STAGES = 7;
    localparam int DAY_REM_W  = 26;
    localparam int REST_W     = DIGIT_W * DIV_STAGES;
    localparam int TOP_W      = 64 - DAY_SHIFT - REST_W;

    // reciprocal of MIN_UNIT, estimate low by at most one
    localparam int RECIP_SHIFT = 52;
    localparam logic [63:0] RECIP_M = (64'd1 << RECIP_SHIFT) / MIN_UNIT;

    // minute / 60 by multiply and shift, exact below one day
    localparam int HOUR_SHIFT = 16;
    localparam logic [63:0] HOUR_RECIP = ((64'd1 << HOUR_SHIFT) / 64'd60) + 64'd1;

    localparam int MINUTE_W = 11;
    localparam int SUBHI_W  = 21;
    localparam int LEAD_W   = 30;

    // pipeline depth from start to done
    localparam int LATENCY = DIV_STAGES + 6;

    // configuration register indexes
    localparam logic [1:0] REG_SIGNAL_MODE  = 2'd0;
    localparam logic [1:0] REG_ALARM_ENABLE = 2'd1;
    localparam logic [1:0] REG_ALARM_HOUR   = 2'd2;
    localparam logic [1:0] REG_ALARM_MINUTE = 2'd3;

    typedef struct packed {
        logic [DAY_REM_W-1:0] rem;
        logic [REST_W-1:0]    rest;
        logic [DAY_SHIFT-1:0] low;
        logic [63:0]          sys;
    } day_beat_t;

    typedef struct packed {
        logic [MINUTE_W-1:0]  minute;
        logic [SUBHI_W-1:0]   sub_hi;
        logic [MIN_SHIFT-1:0] low;
        logic [63:0]          sys;
    } min_beat_t;

    typedef struct packed {
        logic [2:0]          mode;
        logic                alarm_on;
        logic [MINUTE_W-1:0] alarm_at;
    } sched_cfg_t;

    // bit i set when minute-of-hour i is a multiple of step
    function automatic logic [59:0] multiple_mask(input int step);
        logic [59:0] mask;
        int phase;
        mask  = '0;
        phase = 0;
        for (int i = 0; i < MINUTES_PER_HOUR; i++)
        begin
            mask[i] = (phase == 0);
            phase = phase + 1;
            if (phase == step)
            begin
                phase = 0;
            end
        end
        return mask;
    endfunction

    localparam logic [59:0] MINUTE_MASK [0:7] = '{
        60'd0,
        multiple_mask(1),
        multiple_mask(5),
        multiple_mask(10),
        multiple_mask(15),
        multiple_mask(20),
        multiple_mask(30),
        multiple_mask(60)
    };

endpackage

// File: sv/tsts_day_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day reduction digit stage
// One radix-16 step of the long division of the displayed time by a day.
// ----------------------------------------------------------------------------
module tsts_day_div_stage
    import tsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  day_beat_t in_beat,
    output logic      out_valid,
    output day_beat_t out_beat
);

    localparam int T_W = DAY_REM_W + DIGIT_W;

    logic      valid_reg;
    day_beat_t beat_reg;
    day_beat_t beat_next;

    always_comb
    begin
        logic [T_W-1:0] t;
        logic [T_W-1:0] r;
        logic [T_W-1:0] mult;
        t = {in_beat.rem, in_beat.rest[REST_W-1 -: DIGIT_W]};
        r = t;
        // largest multiple of the divisor not above t wins
        for (int j = 1; j < (1 << DIGIT_W); j++)
        begin
            mult = T_W'(DAY_UNIT * 64'(j));
            if (t >= mult)
            begin
                r = t - mult;
            end
        end
        beat_next.rem  = r[DAY_REM_W-1:0];
        beat_next.rest = {in_beat.rest[REST_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        beat_next.low  = in_beat.low;
        beat_next.sys  = in_beat.sys;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: sv/tsts_minute_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minute split
// Splits the time of day into minute of day and ticks into that minute,
// by reciprocal multiply, back multiply and one correction (three stages).
// ----------------------------------------------------------------------------
module tsts_minute_split
    import tsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  day_beat_t in_beat,
    output logic      out_valid,
    output min_beat_t out_beat
);

    localparam int Y_W = DAY_REM_W + DAY_SHIFT - MIN_SHIFT;
    localparam int P_W = Y_W + 32;
    localparam int R_W = SUBHI_W + 1;

    logic [2:0] valid_reg;

    // stage a
    logic [Y_W-1:0]      y_a_reg;
    logic [MINUTE_W-1:0] q_a_reg;
    logic [MIN_SHIFT-1:0] low_a_reg;
    logic [63:0]         sys_a_reg;
    logic [P_W-1:0]      prod_a_next;

    // stage b
    logic [R_W-1:0]      r_b_reg;
    logic [MINUTE_W-1:0] q_b_reg;
    logic [MIN_SHIFT-1:0] low_b_reg;
    logic [63:0]         sys_b_reg;
    logic [Y_W-1:0]      back_b_next;
    logic [Y_W-1:0]      r_b_next;

    // stage c
    min_beat_t           beat_c_reg;
    min_beat_t           beat_c_next;

    logic [Y_W-1:0]      y_in;

    assign y_in        = {in_beat.rem, in_beat.low[DAY_SHIFT-1:MIN_SHIFT]};
    assign prod_a_next = P_W'(y_in) * P_W'(RECIP_M[31:0]);
    assign back_b_next = Y_W'(q_a_reg) * Y_W'(MIN_UNIT);
    assign r_b_next    = y_a_reg - back_b_next;

    always_comb
    begin
        beat_c_next.low = low_b_reg;
        beat_c_next.sys = sys_b_reg;
        if (r_b_reg >= R_W'(MIN_UNIT))
        begin
            beat_c_next.minute = q_b_reg + 1'b1;
            beat_c_next.sub_hi = SUBHI_W'(r_b_reg - R_W'(MIN_UNIT));
        end
        else
        begin
            beat_c_next.minute = q_b_reg;
            beat_c_next.sub_hi = r_b_reg[SUBHI_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        y_a_reg    <= y_in;
        q_a_reg    <= prod_a_next[RECIP_SHIFT +: MINUTE_W];
        low_a_reg  <= in_beat.low[MIN_SHIFT-1:0];
        sys_a_reg  <= in_beat.sys;
        r_b_reg    <= r_b_next[R_W-1:0];
        q_b_reg    <= q_a_reg;
        low_b_reg  <= low_a_reg;
        sys_b_reg  <= sys_a_reg;
        beat_c_reg <= beat_c_next;
    end

    assign out_valid = valid_reg[2];
    assign out_beat  = beat_c_reg;

endmodule

// File: sv/tsts_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target decision
// Matches the next minute against the interval and the alarm, checks the
// lead window and forms the targets (three stages, last one is the output).
// ----------------------------------------------------------------------------
module tsts_decide
    import tsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  min_beat_t   in_beat,
    input  sched_cfg_t  cfg,
    output logic        done,
    output logic        periodic_valid,
    output logic [63:0] periodic_target,
    output logic        alarm_valid,
    output logic [63:0] alarm_target,
    output logic        targets_coincide
);

    localparam int HP_W = MINUTE_W + 11;

    logic [1:0] valid_reg;

    // stage d
    logic [MINUTE_W-1:0] minute_d_reg;
    logic [4:0]          hour_d_reg;
    logic [LEAD_W-1:0]   lead_d_reg;
    logic [63:0]         sys_d_reg;
    logic [HP_W-1:0]     hour_prod;

    // stage e
    logic                pv_e_reg;
    logic                av_e_reg;
    logic [LEAD_W-1:0]   lead_e_reg;
    logic [63:0]         sys_e_reg;
    logic                pv_e_next;
    logic                av_e_next;

    // output stage
    logic                done_reg;
    logic                pv_reg;
    logic                av_reg;
    logic                co_reg;
    logic [63:0]         pt_reg;
    logic [63:0]         at_reg;
    logic [63:0]         target_sum;

    assign hour_prod = HP_W'(in_beat.minute) * HP_W'(HOUR_RECIP);

    always_comb
    begin
        logic [5:0]          mm;
        logic [5:0]          mm_next;
        logic [MINUTE_W-1:0] m_next;
        logic                lead_ok;
        mm = 6'(minute_d_reg - MINUTE_W'(hour_d_reg) * MINUTE_W'(MINUTES_PER_HOUR));
        mm_next = (mm == 6'(MINUTES_PER_HOUR - 1)) ? 6'd0 : mm + 6'd1;
        m_next  = (minute_d_reg == MINUTE_W'(MINUTES_PER_DAY - 1)) ? '0
                                                                   : minute_d_reg + 1'b1;
        lead_ok = (lead_d_reg >= LEAD_W'(LEAD_MIN)) && (lead_d_reg <= LEAD_W'(LEAD_MAX));
        // both leads equal one minute less the ticks into the current minute
        pv_e_next = lead_ok && MINUTE_MASK[cfg.mode][mm_next];
        av_e_next = lead_ok && cfg.alarm_on && (m_next == cfg.alarm_at);
    end

    assign target_sum = sys_e_reg + 64'(lead_e_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
            done_reg  <= valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        minute_d_reg <= in_beat.minute;
        hour_d_reg   <= hour_prod[HOUR_SHIFT +: 5];
        lead_d_reg   <= LEAD_W'(TICKS_PER_MIN) - {in_beat.sub_hi, in_beat.low};
        sys_d_reg    <= in_beat.sys;
        pv_e_reg     <= pv_e_next;
        av_e_reg     <= av_e_next;
        lead_e_reg   <= lead_d_reg;
        sys_e_reg    <= sys_d_reg;
        pv_reg       <= pv_e_reg;
        av_reg       <= av_e_reg;
        co_reg       <= pv_e_reg && av_e_reg;
        pt_reg       <= pv_e_reg ? target_sum : '0;
        at_reg       <= av_e_reg ? target_sum : '0;
    end

    assign done             = done_reg;
    assign periodic_valid   = pv_reg;
    assign alarm_valid      = av_reg;
    assign targets_coincide = co_reg;
    assign periodic_target  = pt_reg;
    assign alarm_target     = at_reg;

endmodule

// File: sv/time_signal_target_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time signal target scheduler core
// Periodic and alarm time signal targets from displayed and system time.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive displayed_time and system_time with start high; the
//   beat is taken at the clock edge where start is high and busy is low.
//   busy stays low, so a new beat can be taken every cycle.
//   Result beat: done is high for exactly one cycle with periodic_valid,
//   periodic_target, alarm_valid, alarm_target and targets_coincide. Every
//   input beat gives one result beat, in order.
//   Pipeline: 7 radix-16 long-division stages reducing the time to a day,
//   3 stages splitting off the minute, 3 stages of matching and target add.
//   Throughput: one beat per cycle.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   at the clock edge (0 signal_mode, 1 alarm_enable, 2 alarm_hour,
//   3 alarm_minute); write only while no beat is in flight.
//   Reset: rst_n clears the registers to 0 and empties the pipeline.
//   The receiver cannot stall; results are strobed and must be taken.
// ----------------------------------------------------------------------------
module time_signal_target_scheduler_core
    import tsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] displayed_time,
    input  logic [63:0] system_time,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output logic        done,
    output logic        periodic_valid,
    output logic [63:0] periodic_target,
    output logic        alarm_valid,
    output logic [63:0] alarm_target,
    output logic        targets_coincide
);

    logic [2:0] signal_mode_reg;
    logic       alarm_enable_reg;
    logic [4:0] alarm_hour_reg;
    logic [5:0] alarm_minute_reg;

    sched_cfg_t cfg;

    logic      div_valid [0:DIV_STAGES];
    day_beat_t div_beat  [0:DIV_STAGES];

    logic      split_valid;
    min_beat_t split_beat;

    // fully pipelined, never holds off a beat
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signal_mode_reg  <= '0;
            alarm_enable_reg <= 1'b0;
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIGNAL_MODE:  signal_mode_reg  <= cfg_data[2:0];
                REG_ALARM_ENABLE: alarm_enable_reg <= cfg_data[0];
                REG_ALARM_HOUR:   alarm_hour_reg   <= cfg_data[4:0];
                REG_ALARM_MINUTE: alarm_minute_reg <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode     = signal_mode_reg;
        cfg.alarm_on = alarm_enable_reg
                    && (alarm_hour_reg < 5'(HOURS_PER_DAY))
                    && (alarm_minute_reg < 6'(MINUTES_PER_HOUR));
        cfg.alarm_at = MINUTE_W'(alarm_hour_reg) * MINUTE_W'(MINUTES_PER_HOUR)
                     + MINUTE_W'(alarm_minute_reg);
    end

    assign div_valid[0]     = start && !busy;
    assign div_beat[0].rem  = DAY_REM_W'(displayed_time[63 -: TOP_W]);
    assign div_beat[0].rest = displayed_time[DAY_SHIFT +: REST_W];
    assign div_beat[0].low  = displayed_time[DAY_SHIFT-1:0];
    assign div_beat[0].sys  = system_time;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_div
            tsts_day_div_stage u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (div_valid[g]),
                .in_beat   (div_beat[g]),
                .out_valid (div_valid[g+1]),
                .out_beat  (div_beat[g+1])
            );
        end
    endgenerate

    tsts_minute_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_beat   (div_beat[DIV_STAGES]),
        .out_valid (split_valid),
        .out_beat  (split_beat)
    );

    tsts_decide u_decide (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (split_valid),
        .in_beat          (split_beat),
        .cfg              (cfg),
        .done             (done),
        .periodic_valid   (periodic_valid),
        .periodic_target  (periodic_target),
        .alarm_valid      (alarm_valid),
        .alarm_target     (alarm_target),
        .targets_coincide (targets_coincide)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted beat did not complete on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input beat");

    a_coincide: assert property (@(posedge clk) disable iff (!rst_n)
        done && targets_coincide |-> periodic_valid && alarm_valid
                                     && (periodic_target == alarm_target))
        else $error("coincide flag without two equal valid targets");

    a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (periodic_valid || (periodic_target == '0))
              && (alarm_valid || (alarm_target == '0)))
        else $error("invalid target not zero");

endmodule

// File: test/tsts_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time signal target scheduler: result checker
// Tracks register writes, predicts the periodic and alarm targets for every
// accepted input beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module tsts_check
    import tsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] displayed_time,
    input  logic [63:0] system_time,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        done,
    input  logic        periodic_valid,
    input  logic [63:0] periodic_target,
    input  logic        alarm_valid,
    input  logic [63:0] alarm_target,
    input  logic        targets_coincide,
    output int          outstanding,
    output int          mismatch_count
);

    localparam logic [63:0] COINCIDE_TOL = 64'd500 * TICKS_PER_MS;
    localparam int          PRINT_CAP    = 40;

    typedef struct packed {
        logic        pv;
        logic [63:0] pt;
        logic        av;
        logic [63:0] at;
        logic        co;
    } sched_result_t;

    logic [2:0]    mode_q;
    logic          alarm_on_q;
    logic [4:0]    hour_q;
    logic [5:0]    minute_q;
    sched_result_t targets_q[$];
    int            err_total;
    int            result_no;

    assign mismatch_count = err_total;

    function automatic logic [63:0] step_ticks(input logic [2:0] mode);
        case (mode)
            3'd1: return 64'd1 * TICKS_PER_MIN;
            3'd2: return 64'd5 * TICKS_PER_MIN;
            3'd3: return 64'd10 * TICKS_PER_MIN;
            3'd4: return 64'd15 * TICKS_PER_MIN;
            3'd5: return 64'd20 * TICKS_PER_MIN;
            3'd6: return 64'd30 * TICKS_PER_MIN;
            3'd7: return 64'd60 * TICKS_PER_MIN;
            default: return 64'd0;
        endcase
    endfunction

    function automatic sched_result_t predict_targets(input logic [63:0] disp,
                                                      input logic [63:0] sys);
        logic [63:0]   iv;
        logic [63:0]   rem;
        logic [63:0]   lead;
        logic [63:0]   tod;
        logic [63:0]   alarm_tick;
        logic [63:0]   diff;
        sched_result_t r;
        r  = '0;
        iv = step_ticks(mode_q);
        if (iv != 64'd0)
        begin
            rem  = disp % iv;
            // landing exactly on a boundary means a whole interval to go
            lead = (rem == 64'd0) ? iv : iv - rem;
            if (lead >= LEAD_MIN && lead <= LEAD_MAX)
            begin
                r.pv = 1'b1;
                r.pt = sys + lead;
            end
        end
        if (alarm_on_q && hour_q < HOURS_PER_DAY && minute_q < MINUTES_PER_HOUR)
        begin
            tod        = disp % TICKS_PER_DAY;
            alarm_tick = (64'(hour_q) * 64'd60 + 64'(minute_q)) * TICKS_PER_MIN;
            lead       = (alarm_tick > tod) ? alarm_tick - tod
                                            : TICKS_PER_DAY - tod + alarm_tick;
            if (lead >= LEAD_MIN && lead <= LEAD_MAX)
            begin
                r.av = 1'b1;
                r.at = sys + lead;
            end
        end
        if (r.pv && r.av)
        begin
            // plain unsigned distance, no modular wrap
            diff = (r.pt >= r.at) ? r.pt - r.at : r.at - r.pt;
            r.co = (diff <= COINCIDE_TOL);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_total < PRINT_CAP)
        begin
            $display("ERROR @%0t result %0d: %s", $realtime, result_no, msg);
        end
        err_total++;
    endtask

    initial
    begin
        err_total = 0;
        result_no = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            mode_q     = '0;
            alarm_on_q = 1'b0;
            hour_q     = '0;
            minute_q   = '0;
            targets_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SIGNAL_MODE:  mode_q     = cfg_data[2:0];
                    REG_ALARM_ENABLE: alarm_on_q = cfg_data[0];
                    REG_ALARM_HOUR:   hour_q     = cfg_data[4:0];
                    REG_ALARM_MINUTE: minute_q   = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                targets_q.push_back(predict_targets(displayed_time, system_time));
            end
            if (done)
            begin
                if (targets_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = targets_q.pop_front();
                    if (periodic_valid !== want.pv)
                        report_mismatch($sformatf("periodic_valid got %b want %b",
                                                  periodic_valid, want.pv));
                    if (periodic_target !== want.pt)
                        report_mismatch($sformatf("periodic_target got %h want %h",
                                                  periodic_target, want.pt));
                    if (alarm_valid !== want.av)
                        report_mismatch($sformatf("alarm_valid got %b want %b",
                                                  alarm_valid, want.av));
                    if (alarm_target !== want.at)
                        report_mismatch($sformatf("alarm_target got %h want %h",
                                                  alarm_target, want.at));
                    if (targets_coincide !== want.co)
                        report_mismatch($sformatf("targets_coincide got %b want %b",
                                                  targets_coincide, want.co));
                end
                result_no++;
            end
            outstanding <= targets_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time signal target scheduler: testbench top
// Directed beats around lead-window edges, alarm matches and bad alarm
// settings, then register phases of random beats aimed near interval and
// alarm boundaries, with random sender gaps. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import tsts_pkg::*;

    localparam int CYCLE_LIMIT     = 150000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CALM_PHASES     = 2;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] displayed_time;
    logic [63:0] system_time;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        done;
    logic        periodic_valid;
    logic [63:0] periodic_target;
    logic        alarm_valid;
    logic [63:0] alarm_target;
    logic        targets_coincide;
    int          outstanding;
    int          mismatch_count;
    int          cycle_count;

    // stimulus-side view of the registers, used only to aim beats
    logic [2:0]  cur_mode;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic        allow_idle;

    int plan_mode   [8] = '{1, 7, 0, 4, 2, 3, 5, 6};
    int plan_enable [8] = '{1, 1, 1, 0, 1, 1, 1, 1};
    int plan_hour   [8] = '{0, 23, 12, 5, 31, 7, 24, 18};
    int plan_minute [8] = '{0, 59, 30, 15, 63, 60, 20, 30};

    time_signal_target_scheduler_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .displayed_time   (displayed_time),
        .system_time      (system_time),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .periodic_valid   (periodic_valid),
        .periodic_target  (periodic_target),
        .alarm_valid      (alarm_valid),
        .alarm_target     (alarm_target),
        .targets_coincide (targets_coincide)
    );

    tsts_check u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .displayed_time   (displayed_time),
        .system_time      (system_time),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .periodic_valid   (periodic_valid),
        .periodic_target  (periodic_target),
        .alarm_valid      (alarm_valid),
        .alarm_target     (alarm_target),
        .targets_coincide (targets_coincide),
        .outstanding      (outstanding),
        .mismatch_count   (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] interval_ticks(input logic [2:0] mode);
        int minutes [8] = '{0, 1, 5, 10, 15, 20, 30, 60};
        return 64'(minutes[mode]) * TICKS_PER_MIN;
    endfunction

    // beat is taken at the first edge with busy low; start stays up unless a gap follows
    task automatic send_sample(input logic [63:0] disp, input logic [63:0] sys);
        int gap;
        displayed_time <= disp;
        system_time    <= sys;
        start          <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            start          <= 1'b0;
            displayed_time <= rand64();
            system_time    <= rand64();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // unused upper data bits carry junk; the register must ignore them
    task automatic program_regs(input logic [2:0] mode, input logic en,
                                input logic [4:0] hour, input logic [5:0] minute);
        cfg_write <= 1'b1;
        cfg_index <= REG_SIGNAL_MODE;
        cfg_data  <= {3'($urandom), mode};
        @(posedge clk);
        cfg_index <= REG_ALARM_ENABLE;
        cfg_data  <= {5'($urandom), en};
        @(posedge clk);
        cfg_index <= REG_ALARM_HOUR;
        cfg_data  <= {1'($urandom), hour};
        @(posedge clk);
        cfg_index <= REG_ALARM_MINUTE;
        cfg_data  <= minute;
        @(posedge clk);
        cfg_write    <= 1'b0;
        cur_mode     = mode;
        cur_hour     = hour;
        cur_minute   = minute;
    endtask

    task automatic random_sample();
        logic [63:0] base;
        logic [63:0] iv;
        logic [63:0] alarm_tick;
        logic [63:0] lead;
        logic [63:0] disp;
        logic [63:0] sys;
        int          kind;
        case ($urandom_range(0, 9))
            0: lead = LEAD_MIN;
            1: lead = LEAD_MAX;
            2: lead = LEAD_MIN - 64'd1;
            3: lead = LEAD_MAX + 64'd1;
            default: lead = 64'($urandom_range(44000000, 56000000));
        endcase
        kind = $urandom_range(0, 9);
        base = rand64();
        if (kind <= 1)
        begin
            disp = base;
        end
        else if (kind <= 5)
        begin
            iv   = interval_ticks((cur_mode == 3'd0) ? 3'($urandom_range(1, 7)) : cur_mode);
            disp = base - base % iv + iv - lead;
        end
        else
        begin
            if (cur_hour < HOURS_PER_DAY && cur_minute < MINUTES_PER_HOUR)
                alarm_tick = (64'(cur_hour) * 64'd60 + 64'(cur_minute)) * TICKS_PER_MIN;
            else
                alarm_tick = 64'($urandom_range(0, MINUTES_PER_DAY - 1)) * TICKS_PER_MIN;
            disp = base - base % TICKS_PER_DAY + alarm_tick - lead;
        end
        case ($urandom_range(0, 7))
            // targets can wrap past 2^64
            0: sys = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 60000000));
            1: sys = 64'($urandom_range(0, 1000));
            default: sys = rand64();
        endcase
        send_sample(disp, sys);
    endtask

    initial
    begin
        logic [63:0] hour_tick;
        hour_tick      = 64'd60 * TICKS_PER_MIN;
        rst_n          = 1'b0;
        start          = 1'b0;
        displayed_time = '0;
        system_time    = '0;
        cfg_write      = 1'b0;
        cfg_index      = REG_SIGNAL_MODE;
        cfg_data       = '0;
        cur_mode       = '0;
        cur_hour       = '0;
        cur_minute     = '0;
        allow_idle     = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no interval, alarm off
        send_sample(64'd0, 64'd0);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(hour_tick - LEAD_MIN, rand64());
        drain_results();

        // hourly signal, alarm 23:59: lead window edges and exact matches
        program_regs(3'd7, 1'b1, 5'd23, 6'd59);
        send_sample(hour_tick - LEAD_MIN, 64'd0);
        send_sample(hour_tick - LEAD_MAX, rand64());
        send_sample(hour_tick - LEAD_MIN + 64'd1, rand64());
        send_sample(hour_tick - LEAD_MAX - 64'd1, rand64());
        send_sample(hour_tick * 64'd5, rand64());
        send_sample(TICKS_PER_DAY - TICKS_PER_MIN - LEAD_MIN, rand64());
        send_sample(TICKS_PER_DAY - TICKS_PER_MIN, rand64());
        send_sample(TICKS_PER_DAY - LEAD_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(64'd0, 64'd0);
        drain_results();

        // alarm at midnight lines up with the hourly signal
        program_regs(3'd7, 1'b1, 5'd0, 6'd0);
        send_sample(TICKS_PER_DAY * 64'd3 - LEAD_MIN, 64'hFFFF_FFFF_FFFF_FFF0);
        send_sample(TICKS_PER_DAY - 64'd50000000, rand64());
        send_sample(TICKS_PER_DAY * 64'd1000 - LEAD_MAX, rand64());
        drain_results();

        // alarm hour and minute out of range, alone and together
        program_regs(3'd1, 1'b1, 5'd24, 6'd60);
        send_sample(TICKS_PER_MIN - 64'd50000000, rand64());
        send_sample(TICKS_PER_DAY - 64'd50000000, rand64());
        drain_results();
        program_regs(3'd1, 1'b1, 5'd31, 6'd63);
        send_sample(TICKS_PER_DAY - 64'd50000000, rand64());
        drain_results();
        program_regs(3'd1, 1'b1, 5'd12, 6'd60);
        send_sample(hour_tick * 64'd13 - 64'd50000000, rand64());
        drain_results();
        program_regs(3'd1, 1'b1, 5'd24, 6'd0);
        send_sample(TICKS_PER_DAY * 64'd7 - 64'd50000000, rand64());
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 8)
                program_regs(3'(plan_mode[p]), 1'(plan_enable[p]),
                             5'(plan_hour[p]), 6'(plan_minute[p]));
            else
                program_regs(3'($urandom_range(0, 7)), 1'($urandom_range(0, 3) != 0),
                             ($urandom_range(0, 4) == 0) ? 5'($urandom_range(24, 31))
                                                         : 5'($urandom_range(0, 23)),
                             ($urandom_range(0, 4) == 0) ? 6'($urandom_range(60, 63))
                                                         : 6'($urandom_range(0, 59)));
            allow_idle = (p < PHASES - CALM_PHASES);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                random_sample();
            end
            drain_results();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (outstanding != 0)
        begin
            $display("ERROR %0d expected results never arrived", outstanding);
        end
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
